// ===== src/tdf_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and arithmetic helpers of the fhan tracking differentiator
package tdf_pkg;

  typedef logic [63:0] word_t;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

  localparam logic [31:0] SPEED_RST  = 32'd380108800;
  localparam logic [31:0] FILTER_RST = 32'd8589935;
  localparam logic [31:0] STEP_RST   = 32'd4294967;

  localparam word_t INT64_MAX_W = 64'h7FFF_FFFF_FFFF_FFFF;

  // round half up on the shifted product, all ones when it does not fit
  function automatic word_t rnd_sat(word_t lo, logic hi_nz, logic rb);
    word_t res;
    if (hi_nz || (&lo && rb)) begin
      res = '1;
    end else begin
      res = lo + {63'd0, rb};
    end
    return res;
  endfunction

  function automatic word_t mag64(word_t v);
    return v[63] ? ('0 - v) : v;
  endfunction

  function automatic word_t clamp_pos(word_t m);
    return m[63] ? INT64_MAX_W : m;
  endfunction

endpackage

// ===== src/tracking_differentiator_fhan.sv =====
`timescale 1ns / 1ps
// fhan tracking differentiator, bit-serial multiply, square root and divide on one sequencer
// the sequence is shortest when d is zero and longest in the nonlinear zone; the 96-step
//   divider and 64-step root and multiply set the long path
// throughput: one item at a time, the next input is taken in the cycle after the result loads
// the result register holds until transferred while the next item is already being worked on
// reset (synchronous, active low) clears value and rate state and loads the register defaults
module tracking_differentiator_fhan #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  in_target_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_tracked_value,
  output logic signed [DATA_WIDTH-1:0]  out_tracked_rate,
  output logic signed [DATA_WIDTH-1:0]  out_acceleration,
  output logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic [tdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  localparam int IFRAC  = (DATA_WIDTH <= 32) ? 32 : 64 - DATA_WIDTH;
  localparam int SH_D   = 80 - IFRAC;
  localparam int SH_L   = 48 - IFRAC;
  localparam int SH_S   = 32;
  localparam int ERR_SH = IFRAC - 16;
  localparam int EXT_W  = 64 - DATA_WIDTH;

  localparam logic [6:0] N32 = 7'd32;
  localparam logic [6:0] N64 = 7'd64;
  localparam logic [6:0] N96 = 7'd96;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_M2, S_CHK, S_M3, S_LEAD, S_Y, S_AY, S_Z, S_M4, S_SQ, S_HS, S_ZS,
    S_AZ, S_ZC, S_M5, S_DIV, S_DR, S_DR2, S_ACC, S_ACL, S_S6, S_M6, S_X1, S_X2, S_S7,
    S_M7, S_W1, S_W2, S_OUT
  } state_t;

  state_t                  state_r;
  logic [31:0]             sf_r, ff_r, dt_r;
  logic [DATA_WIDTH-1:0]   x_r, w_r, accel_r, goal_r;
  tdf_pkg::word_t          mul_a_r, mul_b_r, dq_r, lead_r, y_r, zone_r, mag_r, root_r;
  logic [127:0]            p_r;
  logic [6:0]              cnt_r;
  logic [67:0]             rem_r;
  logic                    neg_r, flag_r;
  logic                    out_valid_r, out_sat_r;
  logic [DATA_WIDTH-1:0]   out_x_r, out_w_r, out_a_r;

  function automatic tdf_pkg::word_t sext(logic [DATA_WIDTH-1:0] v);
    return {{EXT_W{v[DATA_WIDTH-1]}}, v};
  endfunction

  // top bit is the clip flag
  function automatic logic [DATA_WIDTH:0] clip_sig(tdf_pkg::word_t v);
    logic [DATA_WIDTH:0] res;
    if (&v[63:DATA_WIDTH-1] || ~|v[63:DATA_WIDTH-1]) begin
      res = {1'b0, v[DATA_WIDTH-1:0]};
    end else if (v[63]) begin
      res = {1'b1, 1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b1, 1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  // serial multiplier step, one multiplier bit per cycle
  logic [64:0]    mul_sum;
  logic [127:0]   p_step;
  logic [191:0]   pz;
  tdf_pkg::word_t rnd_d, rnd_l, rnd_s;

  assign mul_sum = {1'b0, p_r[127:64]} + (mul_b_r[0] ? {1'b0, mul_a_r} : 65'd0);
  assign p_step  = {mul_sum, p_r[63:1]};
  assign pz      = {64'd0, p_r};

  // 32-step products sit at p_r[127:32]
  assign rnd_d = tdf_pkg::rnd_sat(pz[SH_D+32 +: 64], |(p_r >> (SH_D + 96)), p_r[SH_D+31]);
  assign rnd_l = tdf_pkg::rnd_sat(pz[SH_L+32 +: 64], |(p_r >> (SH_L + 96)), p_r[SH_L+31]);
  assign rnd_s = tdf_pkg::rnd_sat(pz[SH_S+32 +: 64], |(p_r >> (SH_S + 96)), p_r[SH_S+31]);

  // square root digit, two radicand bits per cycle
  logic [67:0] sq_rem2, sq_trial, sq_rem;
  logic        sq_ge;
  assign sq_rem2  = {rem_r[65:0], p_r[127:126]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_rem2 >= sq_trial;
  assign sq_rem   = sq_ge ? sq_rem2 - sq_trial : sq_rem2;

  // restoring divide step, remainder kept in 64 bits
  tdf_pkg::word_t dv_r1;
  logic           dv_ge;
  assign dv_r1 = {rem_r[62:0], p_r[127]};
  assign dv_ge = dv_r1 >= dq_r;

  tdf_pkg::word_t err_w, w_mag, a_mag;
  logic           y_pos, zone_pos;
  logic [DATA_WIDTH:0] clip_acc, clip_x, clip_w;

  assign err_w    = (sext(x_r) - sext(goal_r)) << ERR_SH;
  assign w_mag    = tdf_pkg::mag64(sext(w_r));
  assign a_mag    = tdf_pkg::mag64(sext(accel_r));
  assign y_pos    = !y_r[63] && (y_r != '0);
  assign zone_pos = !zone_r[63] && (zone_r != '0);
  assign clip_acc = clip_sig(mag_r);
  assign clip_x   = clip_sig(sext(x_r) + mag_r);
  assign clip_w   = clip_sig(sext(w_r) + mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      w_r         <= '0;
      sf_r        <= tdf_pkg::SPEED_RST;
      ff_r        <= tdf_pkg::FILTER_RST;
      dt_r        <= tdf_pkg::STEP_RST;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          tdf_pkg::CFG_SPEED:  sf_r <= cfg_wdata;
          tdf_pkg::CFG_FILTER: ff_r <= cfg_wdata;
          tdf_pkg::CFG_STEP:   dt_r <= cfg_wdata;
          default: ;
        endcase
      end
      // in S_OUT a transfer out is always followed by a reload
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            goal_r  <= in_target_value;
            flag_r  <= 1'b0;
            mul_a_r <= {32'd0, sf_r};
            mul_b_r <= {32'd0, ff_r};
            cnt_r   <= N32;
            p_r     <= '0;
            state_r <= S_M1;
          end
        end
        S_M1: begin
          if (cnt_r != '0) begin
            p_r <= p_step; mul_b_r <= mul_b_r >> 1; cnt_r <= cnt_r - 7'd1;
          end else begin
            mul_a_r <= p_r[95:32];
            mul_b_r <= {32'd0, ff_r};
            cnt_r   <= N32;
            p_r     <= '0;
            state_r <= S_M2;
          end
        end
        S_M2: begin
          if (cnt_r != '0) begin
            p_r <= p_step; mul_b_r <= mul_b_r >> 1; cnt_r <= cnt_r - 7'd1;
          end else begin
            dq_r    <= rnd_d;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (dq_r == '0) begin
            accel_r <= '0;
            state_r <= S_S6;
          end else begin
            y_r     <= err_w;
            mul_a_r <= w_mag;
            neg_r   <= w_r[DATA_WIDTH-1];
            mul_b_r <= {32'd0, ff_r};
            cnt_r   <= N32;
            p_r     <= '0;
            state_r <= S_M3;
          end
        end
        S_M3: begin
          if (cnt_r != '0) begin
            p_r <= p_step; mul_b_r <= mul_b_r >> 1; cnt_r <= cnt_r - 7'd1;
          end else begin
            mag_r   <= tdf_pkg::clamp_pos(rnd_l);
            state_r <= S_LEAD;
          end
        end
        S_LEAD: begin
          lead_r  <= neg_r ? ('0 - mag_r) : mag_r;
          state_r <= S_Y;
        end
        S_Y: begin
          y_r     <= y_r + lead_r;
          state_r <= S_AY;
        end
        S_AY: begin
          mag_r   <= tdf_pkg::mag64(y_r);
          state_r <= S_Z;
        end
        S_Z: begin
          if (mag_r <= dq_r) begin
            // linear zone
            mag_r   <= y_r;
            state_r <= S_ZS;
          end else begin
            mul_a_r <= dq_r;
            mul_b_r <= dq_r + (mag_r << 3);
            cnt_r   <= N64;
            p_r     <= '0;
            state_r <= S_M4;
          end
        end
        S_M4: begin
          if (cnt_r != '0) begin
            p_r <= p_step; mul_b_r <= mul_b_r >> 1; cnt_r <= cnt_r - 7'd1;
          end else begin
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= N64;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_r != '0) begin
            rem_r  <= sq_rem;
            root_r <= {root_r[62:0], sq_ge};
            p_r    <= p_r << 2;
            cnt_r  <= cnt_r - 7'd1;
          end else begin
            mag_r   <= (root_r - dq_r) >> 1;
            state_r <= S_HS;
          end
        end
        S_HS: begin
          if (!y_pos) begin
            mag_r <= '0 - mag_r;
          end
          state_r <= S_ZS;
        end
        S_ZS: begin
          zone_r  <= lead_r + mag_r;
          state_r <= S_AZ;
        end
        S_AZ: begin
          mag_r   <= tdf_pkg::mag64(zone_r);
          state_r <= S_ZC;
        end
        S_ZC: begin
          if (zone_r == '0) begin
            accel_r <= '0;
            state_r <= S_S6;
          end else if (mag_r <= dq_r) begin
            mul_a_r <= mag_r;
            mul_b_r <= {32'd0, sf_r};
            cnt_r   <= N32;
            p_r     <= '0;
            state_r <= S_M5;
          end else begin
            root_r  <= {32'd0, sf_r};
            state_r <= S_ACC;
          end
        end
        S_M5: begin
          if (cnt_r != '0) begin
            p_r <= p_step; mul_b_r <= mul_b_r >> 1; cnt_r <= cnt_r - 7'd1;
          end else begin
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= N96;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r != '0) begin
            rem_r  <= {4'd0, dv_ge ? dv_r1 - dq_r : dv_r1};
            root_r <= {root_r[62:0], dv_ge};
            p_r    <= p_r << 1;
            cnt_r  <= cnt_r - 7'd1;
          end else begin
            mag_r   <= dq_r - rem_r[63:0];
            state_r <= S_DR;
          end
        end
        S_DR: begin
          // round the quotient to nearest
          if (rem_r[63:0] >= mag_r) begin
            root_r <= root_r + 64'd1;
          end
          state_r <= S_DR2;
        end
        S_DR2: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          mag_r   <= zone_pos ? ('0 - root_r) : root_r;
          state_r <= S_ACL;
        end
        S_ACL: begin
          accel_r <= clip_acc[DATA_WIDTH-1:0];
          flag_r  <= flag_r | clip_acc[DATA_WIDTH];
          state_r <= S_S6;
        end
        S_S6: begin
          mul_a_r <= w_mag;
          neg_r   <= w_r[DATA_WIDTH-1];
          mul_b_r <= {32'd0, dt_r};
          cnt_r   <= N32;
          p_r     <= '0;
          state_r <= S_M6;
        end
        S_M6: begin
          if (cnt_r != '0) begin
            p_r <= p_step; mul_b_r <= mul_b_r >> 1; cnt_r <= cnt_r - 7'd1;
          end else begin
            mag_r   <= tdf_pkg::clamp_pos(rnd_s);
            state_r <= S_X1;
          end
        end
        S_X1: begin
          mag_r   <= neg_r ? ('0 - mag_r) : mag_r;
          state_r <= S_X2;
        end
        S_X2: begin
          x_r     <= clip_x[DATA_WIDTH-1:0];
          flag_r  <= flag_r | clip_x[DATA_WIDTH];
          state_r <= S_S7;
        end
        S_S7: begin
          mul_a_r <= a_mag;
          neg_r   <= accel_r[DATA_WIDTH-1];
          mul_b_r <= {32'd0, dt_r};
          cnt_r   <= N32;
          p_r     <= '0;
          state_r <= S_M7;
        end
        S_M7: begin
          if (cnt_r != '0) begin
            p_r <= p_step; mul_b_r <= mul_b_r >> 1; cnt_r <= cnt_r - 7'd1;
          end else begin
            mag_r   <= tdf_pkg::clamp_pos(rnd_s);
            state_r <= S_W1;
          end
        end
        S_W1: begin
          mag_r   <= neg_r ? ('0 - mag_r) : mag_r;
          state_r <= S_W2;
        end
        S_W2: begin
          w_r     <= clip_w[DATA_WIDTH-1:0];
          flag_r  <= flag_r | clip_w[DATA_WIDTH];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_x_r     <= x_r;
            out_w_r     <= w_r;
            out_a_r     <= accel_r;
            out_sat_r   <= flag_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_tracked_value = out_x_r;
  assign out_tracked_rate  = out_w_r;
  assign out_acceleration  = out_a_r;
  assign out_saturated     = out_sat_r;

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r[63:0] < dq_r)
    else $error("divider remainder reached the divisor");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ |-> rem_r <= {3'd0, root_r, 1'b0})
    else $error("root remainder above twice the partial root");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_M1 && !flag_r)
    else $error("transfer in did not restart the sequence");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && !out_valid_r |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not loaded into an empty output register");

endmodule

// ===== tb/sv/tb_tracking_differentiator_fhan.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the fhan tracking differentiator
module tb_tracking_differentiator_fhan;

  localparam int DW = 32;
  localparam logic [tdf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 500;
  localparam int IDLE_LIMIT = 12000;
  localparam longint SIG_HI = 64'sd2147483647;
  localparam longint SIG_LO = -64'sd2147483648;

  typedef struct packed {
    logic [DW-1:0] tracked_value;
    logic [DW-1:0] tracked_rate;
    logic [DW-1:0] acceleration;
    logic          saturated;
  } track_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] in_target_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_tracked_value;
  logic signed [DW-1:0] out_tracked_rate;
  logic signed [DW-1:0] out_acceleration;
  logic out_saturated;
  logic cfg_wr_en = 1'b0;
  logic [tdf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  tracking_differentiator_fhan #(.DATA_WIDTH(DW)) dut (.*);

  initial forever #6 clk = ~clk;

  // predictor copy of state and registers
  longint trk_value, trk_rate;
  logic [63:0] r_speed, r_filter, r_step;

  // field extremes, step responses, saturation
  logic [DW-1:0] directed_targets [11] = '{32'sd0, 32'sh0001_0000, -32'sh0001_0000, 32'sd1,
                                           -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
                                           32'h7FFF_FFFF, 32'sd0, 32'h5555_5555,
                                           32'hAAAA_AAAA};

  logic [DW-1:0] pending_targets[$];
  track_res_t expected_results[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;
  bit no_gaps = 1'b0;
  int in_gap = 0, out_gap = 0;
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;

  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint smul_round(longint a, logic [63:0] b, int s);
    logic [63:0] m;
    m = mul_round(abs64(a), b, s);
    if (m[63]) m = 64'h7FFF_FFFF_FFFF_FFFF;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint clip_sig(longint v, inout bit flag);
    if (v > SIG_HI) begin
      flag = 1'b1;
      return SIG_HI;
    end
    if (v < SIG_LO) begin
      flag = 1'b1;
      return SIG_LO;
    end
    return v;
  endfunction

  // one tracker step: fhan acceleration, then integrate value and rate
  function automatic track_res_t track_step(logic signed [DW-1:0] target);
    bit flag;
    longint goal, x, w, accel, err, lead, y, zone, half;
    logic [63:0] dq, ay, az, m, root, rm;
    logic [127:0] num, quo, rem;
    track_res_t res;
    flag = 1'b0;
    goal = longint'(target);
    x = trk_value;
    w = trk_rate;
    accel = 0;
    dq = mul_round(r_speed * r_filter, r_filter, 48);
    if (dq != 0) begin
      err = (x - goal) <<< 16;
      lead = smul_round(w, r_filter, 16);
      y = err + lead;
      ay = abs64(y);
      if (ay <= dq) begin
        zone = lead + y;
      end else begin
        root = root_floor({64'd0, dq} * {64'd0, dq + (ay << 3)});
        half = longint'((root - dq) >> 1);
        zone = lead + (y > 0 ? half : -half);
      end
      az = abs64(zone);
      if (az <= dq) begin
        num = {64'd0, r_speed} * {64'd0, az};
        quo = num / {64'd0, dq};
        rem = num % {64'd0, dq};
        m = quo[63:0];
        rm = rem[63:0];
        if (rm >= dq - rm) m = m + 1;
      end else begin
        m = r_speed;
      end
      accel = clip_sig(zone > 0 ? -longint'(m) : longint'(m), flag);
      if (zone == 0) accel = 0;
    end
    x = clip_sig(x + smul_round(w, r_step, 32), flag);
    w = clip_sig(w + smul_round(accel, r_step, 32), flag);
    trk_value = x;
    trk_rate = w;
    res.tracked_value = x[DW-1:0];
    res.tracked_rate = w[DW-1:0];
    res.acceleration = accel[DW-1:0];
    res.saturated = flag;
    return res;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // input side: present queued targets at the falling edge
  always @(negedge clk) begin
    logic nxt_valid;
    logic [DW-1:0] nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_target_value;
    if (in_valid && in_taken) nxt_valid = 1'b0;
    if (!nxt_valid && rst_n) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_targets.size() > 0) begin
        nxt_data = pending_targets.pop_front();
        nxt_valid = 1'b1;
        in_gap = no_gaps ? 0 : pick_gap();
      end
    end
    in_valid <= nxt_valid;
    in_target_value <= nxt_data;
  end

  // result side stall, with a single long hold-off
  always @(negedge clk) begin
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      nxt_stall = 1'b1;
    end else if (!no_gaps) begin
      out_gap = pick_gap();
      nxt_stall = out_gap > 0;
    end
    out_stall <= nxt_stall;
  end

  // transfers on both channels, predicted and checked at the rising edge
  always @(posedge clk) begin
    track_res_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) expected_results.push_back(track_step(in_target_value));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tracked_value !== want.tracked_value) begin
          $error("tracked_value: expected %0d, got %0d",
                 $signed(want.tracked_value), out_tracked_value);
          fail_count++;
        end
        if (out_tracked_rate !== want.tracked_rate) begin
          $error("tracked_rate: expected %0d, got %0d",
                 $signed(want.tracked_rate), out_tracked_rate);
          fail_count++;
        end
        if (out_acceleration !== want.acceleration) begin
          $error("acceleration: expected %0d, got %0d",
                 $signed(want.acceleration), out_acceleration);
          fail_count++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_saturated);
          fail_count++;
        end
      end
    end
    if (in_taken || (out_valid && !out_stall) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [tdf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      tdf_pkg::CFG_SPEED: r_speed = {32'd0, val};
      tdf_pkg::CFG_FILTER: r_filter = {32'd0, val};
      tdf_pkg::CFG_STEP: r_step = {32'd0, val};
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_targets.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] rand_target();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return DW'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
    if (k < 8) return DW'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    if (k < 9) return $urandom();
    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  task automatic random_phase(int n);
    logic [DW-1:0] t;
    t = rand_target();
    for (int i = 0; i < n; i++) begin
      // mostly hold a target for a while so the tracker settles on it
      if ($urandom_range(0, 9) < 2) t = rand_target();
      pending_targets.push_back(t);
    end
    drain();
  endtask

  initial begin
    trk_value = 0;
    trk_rate = 0;
    r_speed = {32'd0, tdf_pkg::SPEED_RST};
    r_filter = {32'd0, tdf_pkg::FILTER_RST};
    r_step = {32'd0, tdf_pkg::STEP_RST};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, step responses, saturation, zero d
    foreach (directed_targets[i]) pending_targets.push_back(directed_targets[i]);
    drain();
    write_reg(tdf_pkg::CFG_STEP, 32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) pending_targets.push_back(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    drain();
    write_reg(tdf_pkg::CFG_SPEED, 32'd0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) pending_targets.push_back(32'h0010_0000 << i);
    drain();

    no_gaps = 1'b1;
    write_reg(tdf_pkg::CFG_SPEED, tdf_pkg::SPEED_RST);
    write_reg(tdf_pkg::CFG_STEP, tdf_pkg::STEP_RST);
    random_phase(150);
    no_gaps = 1'b0;
    hold_reqs++;
    random_phase(200);
    write_reg(tdf_pkg::CFG_SPEED, 32'hFFFF_FFFF);
    write_reg(tdf_pkg::CFG_FILTER, 32'hFFFF_FFFF);
    random_phase(120);
    write_reg(tdf_pkg::CFG_FILTER, 32'd0);
    random_phase(60);
    write_reg(tdf_pkg::CFG_STEP, 32'd0);
    write_reg(tdf_pkg::CFG_FILTER, tdf_pkg::FILTER_RST);
    random_phase(60);
    for (int p = 0; p < 6; p++) begin
      write_reg(tdf_pkg::CFG_SPEED,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 32'h2000_0000));
      write_reg(tdf_pkg::CFG_FILTER,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 32'h0100_0000));
      write_reg(tdf_pkg::CFG_STEP,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 32'h0100_0000));
      random_phase(100);
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
